// ===== hw/rtl/rbt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Resource barrier tracker package
// Transaction types, state and access codes shared by the tracker modules,
// and the small decode functions used by the update logic.
// ----------------------------------------------------------------------------
package rbt_pkg;

  // Field widths fixed by the transaction format.
  localparam int unsigned IdxW   = 6;
  localparam int unsigned StateW = 3;

  // Item operations.
  typedef enum logic [1:0] {
    OpBegin  = 2'd0,
    OpAccess = 2'd1,
    OpFinish = 2'd2
  } rbt_op_e;

  // Access kinds.
  localparam logic [1:0] KindSampled = 2'd0;
  localparam logic [1:0] KindColor   = 2'd1;
  localparam logic [1:0] KindDepth   = 2'd2;

  // Resource usage states.
  localparam logic [StateW-1:0] StUndef   = 3'd0;
  localparam logic [StateW-1:0] StPresent = 3'd1;
  localparam logic [StateW-1:0] StTarget  = 3'd2;
  localparam logic [StateW-1:0] StShader  = 3'd3;
  localparam logic [StateW-1:0] StDepth   = 3'd4;

  // Input transaction.
  typedef struct packed {
    logic [1:0]        opcode;
    logic [IdxW-1:0]   resource_index;
    logic [1:0]        access_kind;
    logic [StateW-1:0] start_state;
    logic [StateW-1:0] final_state;
  } rbt_in_t;

  // Result transaction.
  typedef struct packed {
    logic              barrier_valid;
    logic [IdxW-1:0]   barrier_resource;
    logic [StateW-1:0] from_state;
    logic [StateW-1:0] to_state;
    logic [StateW-1:0] end_state;
  } rbt_out_t;

  // Table write port.
  typedef struct packed {
    logic              en;
    logic [IdxW-1:0]   idx;
    logic [StateW-1:0] state;
  } rbt_wr_t;

  // State an access kind requires; the unused kind requires nothing.
  function automatic logic [StateW-1:0] need_of_kind(input logic [1:0] kind);
    logic [StateW-1:0] need;
    case (kind)
      KindSampled: need = StShader;
      KindColor:   need = StTarget;
      KindDepth:   need = StDepth;
      default:     need = StUndef;
    endcase
    return need;
  endfunction

  // Codes above the depth state fold to undefined.
  function automatic logic [StateW-1:0] clean_state(input logic [StateW-1:0] s);
    return (s > StDepth) ? StUndef : s;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rbt_state_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Resource barrier tracker state table
// One-write, one-read state memory with per-entry valid bits and a write
// bypass on the registered read port.
// ----------------------------------------------------------------------------
module rbt_state_table #(
  parameter int unsigned RESOURCE_COUNT = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        rd_en_i,
  input  wire logic [rbt_pkg::IdxW-1:0]    rd_idx_i,
  input  wire rbt_pkg::rbt_wr_t            wr_i,
  output logic [rbt_pkg::StateW-1:0]       rd_state_o
);
  import rbt_pkg::*;

  localparam int unsigned Depth = (RESOURCE_COUNT > (2 ** IdxW)) ? (2 ** IdxW)
                                                                 : RESOURCE_COUNT;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Rows  = 2 ** AddrW;

  logic [StateW-1:0] mem [Rows];
  logic [Rows-1:0]   valid_q;
  logic [StateW-1:0] rd_data_q;
  logic              rd_valid_q;
  logic [AddrW-1:0]  rd_addr;
  logic [AddrW-1:0]  wr_addr;
  logic              bypass;

  assign rd_addr = rd_idx_i[AddrW-1:0];
  assign wr_addr = wr_i.idx[AddrW-1:0];
  assign bypass  = wr_i.en && (wr_addr == rd_addr);

  // Data array, written by the retiring item.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr] <= wr_i.state;
    end
  end

  // Valid bits: an entry never written reads as undefined.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  // Registered read; a write in the same cycle to the same entry is forwarded.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= bypass ? wr_i.state : mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (rd_en_i) begin
      rd_valid_q <= bypass || valid_q[rd_addr];
    end
  end

  assign rd_state_o = rd_valid_q ? rd_data_q : StUndef;

endmodule
`default_nettype wire

// ===== hw/rtl/rbt_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Resource barrier tracker update logic
// Works out the new table state and the barrier for one item from the
// resource's current state.
// ----------------------------------------------------------------------------
module rbt_update (
  input  wire rbt_pkg::rbt_in_t              item_i,
  input  wire logic [rbt_pkg::StateW-1:0]    cur_i,
  input  wire logic                          in_range_i,
  output rbt_pkg::rbt_out_t                  res_o,
  output logic [rbt_pkg::StateW-1:0]         next_state_o
);
  import rbt_pkg::*;

  logic [StateW-1:0] need;
  logic [StateW-1:0] fin;
  logic [StateW-1:0] nxt;
  logic              fire;

  assign need = need_of_kind(item_i.access_kind);
  assign fin  = clean_state(item_i.final_state);

  // Transition rules per operation.
  always_comb begin
    nxt  = cur_i;
    fire = 1'b0;
    case (rbt_op_e'(item_i.opcode))
      OpBegin: begin
        nxt = clean_state(item_i.start_state);
      end
      OpAccess: begin
        if (need != StUndef) begin
          nxt = need;
          fire = (cur_i != StUndef) && (need != cur_i);
        end
      end
      OpFinish: begin
        if ((cur_i != StUndef) && (fin != StUndef) && (fin != cur_i)) begin
          nxt = fin;
          fire = 1'b1;
        end
      end
      default: begin
        nxt = cur_i;
      end
    endcase
  end

  // Result; an out-of-range resource gives an all-zero result.
  always_comb begin
    res_o = '0;
    if (in_range_i) begin
      res_o.barrier_valid = fire;
      res_o.end_state     = nxt;
      if (fire) begin
        res_o.barrier_resource = item_i.resource_index;
        res_o.from_state       = cur_i;
        res_o.to_state         = nxt;
      end
    end
  end

  assign next_state_o = nxt;

endmodule
`default_nettype wire

// ===== hw/rtl/resource_barrier_tracker_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Resource barrier tracker
// Tracks the usage state of each resource and emits transition barriers.
// ----------------------------------------------------------------------------
// Every input transaction gives exactly one result transaction. The
// accepting edge registers the transaction in the input stage and the read of
// the resource's entry from the state table. The transition rules are then
// applied to the staged transaction, and the edge that moves it on writes the
// entry back and loads the result register. A new transaction can be taken
// every cycle unless the input stalls, which it does only while a staged
// transaction waits behind a stalled result. The table has one read and one
// write port, and a write that hits the entry being read in the same cycle is
// forwarded, so back-to-back transactions on one resource see each other's
// updates. After reset every entry reads as undefined. Indexes at or above
// RESOURCE_COUNT are ignored and return an all-zero result.
// ----------------------------------------------------------------------------
module resource_barrier_tracker_unit #(
  parameter int unsigned RESOURCE_COUNT = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire rbt_pkg::rbt_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output rbt_pkg::rbt_out_t      out_data_o
);
  import rbt_pkg::*;

  logic              s1_valid_q;
  rbt_in_t           s1_item_q;
  logic              out_valid_q;
  rbt_out_t          out_data_q;
  logic              res_load;
  logic              s1_adv;
  logic              in_fire;
  logic              in_range;
  logic [StateW-1:0] cur_state;
  logic [StateW-1:0] next_state;
  rbt_out_t          res;
  rbt_wr_t           wr;

  // Handshake: the result register frees when empty or being taken.
  assign res_load   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && res_load;
  assign in_stall_o = s1_valid_q && !res_load;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_range   = 32'(s1_item_q.resource_index) < RESOURCE_COUNT;

  // Table write from the item that retires into the result register.
  assign wr.en    = s1_adv && in_range;
  assign wr.idx   = s1_item_q.resource_index;
  assign wr.state = next_state;

  rbt_state_table #(
    .RESOURCE_COUNT(RESOURCE_COUNT)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_fire),
    .rd_idx_i   (in_data_i.resource_index),
    .wr_i       (wr),
    .rd_state_o (cur_state)
  );

  rbt_update u_update (
    .item_i       (s1_item_q),
    .cur_i        (cur_state),
    .in_range_i   (in_range),
    .res_o        (res),
    .next_state_o (next_state)
  );

  // Input stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire || s1_adv) begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_data_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A new result only comes from an item that sat in the input stage.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a staged transaction");

  // A barrier always moves between two different defined states.
  a_barrier_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.barrier_valid) |->
      (out_data_q.from_state != out_data_q.to_state) &&
      (out_data_q.from_state != StUndef) &&
      (out_data_q.to_state == out_data_q.end_state))
    else $error("malformed barrier");

  // Without a barrier the transition fields are clear.
  a_no_barrier_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q.barrier_valid) |->
      (out_data_q.barrier_resource == '0) && (out_data_q.from_state == StUndef) &&
      (out_data_q.to_state == StUndef))
    else $error("transition fields set without a barrier");

  // Input stalls only while the input stage is held by a blocked result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

endmodule
`default_nettype wire

// ===== bench/barrier_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barrier scoreboard
// Keeps a private copy of the resource state table, works out the barrier
// result for every accepted input transaction and checks the results that
// leave the tracker against those predictions, oldest first.
// ----------------------------------------------------------------------------
package barrier_scoreboard_pkg;
  import rbt_pkg::*;

  class barrier_scoreboard;
    int unsigned       res_count;
    logic [StateW-1:0] usage_state [];
    rbt_out_t          pending_barriers [$];
    int unsigned       failures;

    function new(int unsigned count);
      res_count = count;
      usage_state = new[count];
      foreach (usage_state[i]) begin
        usage_state[i] = StUndef;
      end
      failures = 0;
    endfunction

    // State codes above the depth state mean undefined or no final state.
    function logic [StateW-1:0] legal_state(logic [StateW-1:0] code);
      return (code > StDepth) ? StUndef : code;
    endfunction

    // Applies one transaction to the table copy and returns the barrier it causes.
    function rbt_out_t next_barrier(rbt_in_t item);
      rbt_out_t          res;
      logic [StateW-1:0] cur;
      logic [StateW-1:0] need;
      logic [StateW-1:0] fin;
      res = '0;
      if (item.resource_index >= res_count) begin
        return res;
      end
      cur = usage_state[item.resource_index];
      case (item.opcode)
        OpBegin: begin
          cur = legal_state(item.start_state);
        end
        OpAccess: begin
          case (item.access_kind)
            KindSampled: need = StShader;
            KindColor:   need = StTarget;
            KindDepth:   need = StDepth;
            default:     need = StUndef;
          endcase
          // An undefined resource adopts the required state silently.
          if (need != StUndef) begin
            if (cur == StUndef) begin
              cur = need;
            end else if (need != cur) begin
              res.barrier_valid    = 1'b1;
              res.barrier_resource = item.resource_index;
              res.from_state       = cur;
              res.to_state         = need;
              cur                  = need;
            end
          end
        end
        OpFinish: begin
          fin = legal_state(item.final_state);
          // A resource whose state is undefined gets no end barrier.
          if (cur != StUndef && fin != StUndef && fin != cur) begin
            res.barrier_valid    = 1'b1;
            res.barrier_resource = item.resource_index;
            res.from_state       = cur;
            res.to_state         = fin;
            cur                  = fin;
          end
        end
        default: begin
        end
      endcase
      usage_state[item.resource_index] = cur;
      res.end_state = cur;
      return res;
    endfunction

    function void note_item(rbt_in_t item);
      pending_barriers.insert(pending_barriers.size(), next_barrier(item));
    endfunction

    function void compare_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
      if (exp_val !== got_val) begin
        failures++;
        $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
      end
    endfunction

    function void check_result(rbt_out_t got);
      rbt_out_t exp;
      if (pending_barriers.size() == 0) begin
        failures++;
        $display("%0t: unexpected result transaction, expected none, got %h",
                 $time, got);
        return;
      end
      exp = pending_barriers.pop_front();
      compare_field("barrier_valid", 8'(exp.barrier_valid), 8'(got.barrier_valid));
      compare_field("barrier_resource", 8'(exp.barrier_resource),
                    8'(got.barrier_resource));
      compare_field("from_state", 8'(exp.from_state), 8'(got.from_state));
      compare_field("to_state", 8'(exp.to_state), 8'(got.to_state));
      compare_field("end_state", 8'(exp.end_state), 8'(got.end_state));
    endfunction

    function int unsigned outstanding();
      return pending_barriers.size();
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resource barrier tracker testbench
// Drives directed corner cases and then random resource lifecycles (an optional
// begin, a run of accesses, finish) mixed with noise transactions, with random
// gaps on the input side and random stalls on the output side. Every
// result transaction is checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import rbt_pkg::*;
  import barrier_scoreboard_pkg::*;

  localparam int unsigned ResCount    = 64;
  localparam int unsigned RandomItems = 1300;
  localparam int unsigned DrainCycles = 6;

  // Codes outside the defined ranges.
  localparam logic [1:0]        OpUnused   = 2'd3;
  localparam logic [1:0]        KindUnused = 2'd3;
  localparam logic [StateW-1:0] StBadLow   = 3'd5;
  localparam logic [StateW-1:0] StBadHigh  = 3'd7;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  rbt_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  rbt_out_t out_data_o;

  barrier_scoreboard sb;
  int unsigned       items_sent = 0;
  bit                calm = 1'b0;
  int unsigned       stall_hold = 0;
  int unsigned       stall_pick;

  resource_barrier_tracker_unit #(
    .RESOURCE_COUNT(ResCount)
  ) uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  always #5 clk_i = ~clk_i;

  // Output stalls: mostly open, short stalls often, long stalls rarely.
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (calm || stall_pick < 60) begin
        out_stall_i <= 1'b0;
        stall_hold  <= $urandom_range(0, 12);
      end else if (stall_pick < 94) begin
        out_stall_i <= 1'b1;
        stall_hold  <= $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_hold  <= $urandom_range(8, 40);
      end
    end
  end

  // Note every accepted input transaction and check every accepted result.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      sb.note_item(in_data_i);
    end
    if (out_valid_o && !out_stall_i) begin
      sb.check_result(out_data_o);
    end
  end

  function automatic rbt_in_t make_item(logic [1:0] op, logic [IdxW-1:0] idx,
                                        logic [1:0] kind, logic [StateW-1:0] st,
                                        logic [StateW-1:0] fin);
    rbt_in_t item;
    item.opcode         = op;
    item.resource_index = idx;
    item.access_kind    = kind;
    item.start_state    = st;
    item.final_state    = fin;
    return item;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (calm || p < 55) begin
      return 0;
    end else if (p < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Mostly defined state codes, sometimes the folded ones.
  function automatic logic [StateW-1:0] pick_state();
    if ($urandom_range(0, 99) < 85) begin
      return StateW'($urandom_range(StUndef, StDepth));
    end
    return StateW'($urandom_range(StBadLow, StBadHigh));
  endfunction

  // A few hot resources so that back-to-back transactions hit the same entry.
  function automatic logic [IdxW-1:0] pick_resource();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p < 4) begin
      return IdxW'($urandom_range(0, 3));
    end else if (p < 6) begin
      return IdxW'($urandom_range(60, 63));
    end
    return IdxW'($urandom_range(0, 63));
  endfunction

  task automatic send_item(input rbt_in_t item);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i  <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Hold the input idle until every predicted result has left the block.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  task automatic send_noise();
    send_item(make_item(2'($urandom_range(0, 3)), IdxW'($urandom_range(0, 63)),
                        2'($urandom_range(0, 3)), StateW'($urandom_range(0, 7)),
                        StateW'($urandom_range(0, 7))));
  endtask

  // One resource lifecycle: an optional begin, a run of accesses, a finish.
  task automatic run_lifecycle();
    logic [IdxW-1:0] res;
    logic [1:0]      kind;
    int unsigned     n_access;
    res = pick_resource();
    if ($urandom_range(0, 9) < 8) begin
      send_item(make_item(OpBegin, res, 2'($urandom_range(0, 3)), pick_state(),
                          StateW'($urandom_range(0, 7))));
    end
    n_access = $urandom_range(1, 6);
    repeat (n_access) begin
      kind = ($urandom_range(0, 9) == 0) ? KindUnused : 2'($urandom_range(0, 2));
      send_item(make_item(OpAccess, res, kind, StateW'($urandom_range(0, 7)),
                          StateW'($urandom_range(0, 7))));
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end
    end
    send_item(make_item(OpFinish, res, 2'($urandom_range(0, 3)),
                        StateW'($urandom_range(0, 7)), pick_state()));
  endtask

  initial begin
    int unsigned random_end;
    int unsigned next_drain;
    sb = new(ResCount);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner cases.
    send_item(make_item(OpFinish, 6'd5, KindSampled, StUndef, StShader));
    send_item(make_item(OpAccess, 6'd0, KindSampled, StUndef, StUndef));
    send_item(make_item(OpAccess, 6'd0, KindColor, StUndef, StUndef));
    send_item(make_item(OpAccess, 6'd0, KindColor, StUndef, StUndef));
    send_item(make_item(OpAccess, 6'd0, KindDepth, StUndef, StUndef));
    send_item(make_item(OpAccess, 6'd0, KindUnused, StUndef, StUndef));
    send_item(make_item(OpFinish, 6'd0, KindSampled, StUndef, StUndef));
    send_item(make_item(OpFinish, 6'd0, KindSampled, StUndef, StDepth));
    send_item(make_item(OpFinish, 6'd0, KindSampled, StUndef, StPresent));
    send_item(make_item(OpBegin, 6'd63, KindSampled, StPresent, StUndef));
    send_item(make_item(OpAccess, 6'd63, KindDepth, StUndef, StUndef));
    send_item(make_item(OpBegin, 6'd63, KindSampled, StBadHigh, StUndef));
    send_item(make_item(OpAccess, 6'd63, KindColor, StUndef, StUndef));
    send_item(make_item(OpFinish, 6'd63, KindSampled, StUndef, 3'd6));
    send_item(make_item(OpBegin, 6'd62, KindSampled, StBadLow, StUndef));
    send_item(make_item(OpBegin, 6'd62, KindSampled, StShader, StUndef));
    send_item(make_item(OpUnused, 6'd62, KindDepth, StDepth, StTarget));
    send_item(make_item(OpFinish, 6'd62, KindSampled, StUndef, StTarget));
    send_item(make_item(OpBegin, 6'd1, KindSampled, StTarget, StUndef));
    send_item(make_item(OpAccess, 6'd1, KindSampled, StUndef, StUndef));
    send_item(make_item(OpBegin, 6'd1, KindSampled, StUndef, StUndef));
    send_item(make_item(OpFinish, 6'd1, KindSampled, StUndef, StDepth));
    send_item(make_item(OpUnused, 6'd63, KindUnused, StBadHigh, StBadHigh));
    send_item(make_item(OpBegin, 6'd0, KindSampled, StDepth, StUndef));
    wait_drained();

    // Random lifecycles with noise, calm stretches and occasional full drains.
    random_end = items_sent + RandomItems;
    next_drain = items_sent + 250;
    while (items_sent < random_end) begin
      calm = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) < 8) begin
        run_lifecycle();
      end else begin
        send_noise();
      end
      if (items_sent >= next_drain) begin
        wait_drained();
        next_drain = items_sent + 250;
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("resource_barrier_tracker_unit: match");
    end else begin
      $display("resource_barrier_tracker_unit: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("resource_barrier_tracker_unit: mismatch");
    $finish;
  end

endmodule
